// File: rtl/core/gc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gc_pkg
// shared types and constants of the gate controller: transaction payloads,
// timer control and status, configuration map
// ----------------------------------------------------------------------------
package gc_pkg;

  localparam int unsigned TickW    = 24;
  localparam int unsigned StateW   = 4;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbIdxW  = ApbAddrW - 2;

  localparam logic [TickW-1:0]   RunLimitRst = TickW'(180000);
  localparam logic [ApbIdxW-1:0] RegRunLimit = ApbIdxW'(0);

  typedef struct packed {
    logic open_limit;
    logic closed_limit;
    logic photocell;
    logic push_button;
    logic emergency;
  } gc_in_t;

  typedef struct packed {
    logic              motor_close;
    logic              motor_open;
    logic              lamp;
    logic              buzzer;
    logic [StateW-1:0] gate_state;
  } gc_out_t;

  typedef struct packed {
    logic tick;
    logic clear;
  } gc_tmr_cmd_t;

  typedef struct packed {
    logic arming;
    logic late;
  } gc_tmr_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/gc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gc_in_if
// valid/ready channel carrying one sensor and button sample
// ----------------------------------------------------------------------------
interface gc_in_if;
  import gc_pkg::*;

  logic   valid;
  logic   ready;
  gc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/gc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gc_out_if
// valid/ready channel carrying one set of actuator drives and the state
// ----------------------------------------------------------------------------
interface gc_out_if;
  import gc_pkg::*;

  logic    valid;
  logic    ready;
  gc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/gc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gc_cfg_regs
// apb register file holding the move time limit
// ----------------------------------------------------------------------------
module gc_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gc_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [gc_pkg::ApbDataW-1:0]  pwdata,
  output logic      [gc_pkg::ApbDataW-1:0]  prdata,
  output logic                              pready,
  output logic      [gc_pkg::TickW-1:0]     run_limit_o
);
  import gc_pkg::*;

  logic [TickW-1:0]   run_limit_q, run_limit_d;
  logic [ApbIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    run_limit_d = run_limit_q;
    if (wr_en && (reg_idx == RegRunLimit)) begin
      run_limit_d = pwdata[TickW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_limit_q <= RunLimitRst;
    end else begin
      run_limit_q <= run_limit_d;
    end
  end

  assign prdata      = (reg_idx == RegRunLimit) ? ApbDataW'(run_limit_q) : '0;
  assign run_limit_o = run_limit_q;
endmodule
`default_nettype wire

// File: rtl/core/gc_move_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gc_move_timer
// saturating move duration counter with arming tick and limit compare
// ----------------------------------------------------------------------------
module gc_move_timer (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire gc_pkg::gc_tmr_cmd_t      cmd_i,
  input  wire logic [gc_pkg::TickW-1:0] run_limit_i,
  output gc_pkg::gc_tmr_sts_t           sts_o
);
  import gc_pkg::*;

  logic             armed_q, armed_d;
  logic [TickW-1:0] ticks_q, ticks_d;
  logic [TickW:0]   ticks_inc;
  logic [TickW-1:0] ticks_sat;

  // compare uses the unsaturated count
  assign ticks_inc    = {1'b0, ticks_q} + (TickW+1)'(1);
  assign ticks_sat    = ticks_inc[TickW] ? '1 : ticks_inc[TickW-1:0];
  assign sts_o.arming = !armed_q;
  assign sts_o.late   = armed_q && (ticks_inc > {1'b0, run_limit_i});

  always_comb begin
    armed_d = armed_q;
    ticks_d = ticks_q;
    if (step_i) begin
      if (cmd_i.clear) begin
        armed_d = 1'b0;
        ticks_d = '0;
      end else if (cmd_i.tick) begin
        armed_d = 1'b1;
        ticks_d = armed_q ? ticks_sat : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      ticks_q <= '0;
    end else begin
      armed_q <= armed_d;
      ticks_q <= ticks_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/gc_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gc_fsm
// gate state machine with button edge detect and registered result
// ----------------------------------------------------------------------------
module gc_fsm (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gc_in_if.sink                    in_i,
  gc_out_if.source                 out_o,
  input  wire gc_pkg::gc_tmr_sts_t tmr_sts_i,
  output gc_pkg::gc_tmr_cmd_t      tmr_cmd_o,
  output logic                     step_o
);
  import gc_pkg::*;

  typedef enum logic [StateW-1:0] {
    StStart    = StateW'(0),
    StUnknown  = StateW'(1),
    StClosing  = StateW'(2),
    StOpening  = StateW'(3),
    StClosed   = StateW'(4),
    StOpen     = StateW'(5),
    StObjStop  = StateW'(6),
    StUserStop = StateW'(7),
    StError    = StateW'(8)
  } mode_e;

  mode_e   mode_q, mode_d;
  logic    btn_last_q;
  logic    swc_q, swc_d;
  logic    out_valid_q;
  gc_out_t out_data_q, res;
  logic    accept;
  logic    btn_rise;
  gc_in_t  smp;

  assign smp        = in_i.data;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign step_o     = accept;
  assign btn_rise   = smp.push_button && !btn_last_q;

  always_comb begin
    mode_d         = mode_q;
    swc_d          = swc_q;
    tmr_cmd_o      = '0;
    res            = '0;
    res.gate_state = mode_q;
    unique case (mode_q)
      StStart: begin
        tmr_cmd_o.clear = 1'b1;
        mode_d          = StUnknown;
      end
      StUnknown: begin
        res.motor_close = 1'b1;
        res.buzzer      = 1'b1;
        tmr_cmd_o.tick  = 1'b1;
        if (!tmr_sts_i.arming) begin
          if (smp.closed_limit) begin
            mode_d          = StClosed;
            tmr_cmd_o.clear = 1'b1;
          end else if (tmr_sts_i.late) begin
            mode_d = StError;
          end
        end
      end
      StClosing: begin
        res.motor_close = 1'b1;
        res.buzzer      = 1'b1;
        tmr_cmd_o.tick  = 1'b1;
        if (!tmr_sts_i.arming) begin
          if (smp.closed_limit) begin
            mode_d          = StClosed;
            tmr_cmd_o.clear = 1'b1;
          end else if (smp.photocell) begin
            mode_d          = StObjStop;
            tmr_cmd_o.clear = 1'b1;
          end else if (btn_rise) begin
            mode_d          = StUserStop;
            swc_d           = 1'b1;
            tmr_cmd_o.clear = 1'b1;
          end else if (tmr_sts_i.late) begin
            mode_d = StError;
          end
        end
      end
      StOpening: begin
        res.motor_open = 1'b1;
        res.lamp       = 1'b1;
        res.buzzer     = 1'b1;
        tmr_cmd_o.tick = 1'b1;
        if (!tmr_sts_i.arming) begin
          if (smp.open_limit) begin
            mode_d          = StOpen;
            tmr_cmd_o.clear = 1'b1;
          end else if (btn_rise) begin
            mode_d          = StUserStop;
            swc_d           = 1'b0;
            tmr_cmd_o.clear = 1'b1;
          end else if (tmr_sts_i.late) begin
            mode_d = StError;
          end
        end
      end
      StClosed: begin
        if (btn_rise) mode_d = StOpening;
      end
      StOpen: begin
        if (btn_rise) mode_d = StClosing;
      end
      StObjStop: begin
        if (btn_rise) mode_d = StOpening;
      end
      StUserStop: begin
        if (btn_rise) mode_d = swc_q ? StClosing : StOpening;
      end
      StError: begin
        if (smp.emergency) mode_d = StStart;
      end
      default: begin
        mode_d = StError;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= StStart;
      btn_last_q  <= 1'b0;
      swc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        btn_last_q  <= smp.push_button;
        swc_q       <= swc_d;
        out_data_q  <= res;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;
endmodule
`default_nettype wire

// File: rtl/core/gate_controller_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gate_controller_fsm
// automatic gate controller, one sensor sample per scan tick
// ----------------------------------------------------------------------------
// in_i carries one sample per transaction: limit switches, photocell, push
// button level and emergency input. out_o returns one transaction per sample
// with the motor, lamp and buzzer drives and the state handled for it.
// The apb port holds run_limit at byte address 0; pready is always high and
// it should only be written while no sample is in flight.
// A result is registered at the edge that accepts its sample. Throughput is
// one sample per cycle while the receiver is ready, set by the single state
// register and the result register.
// While the receiver stalls, the result register holds its transaction and a
// new sample is taken in the same cycle the held one drains.
// Reset puts the controller in the start state with the move timer cleared,
// the button edge history low and run_limit at 180000 ticks.
// ----------------------------------------------------------------------------
module gate_controller_fsm (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gc_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [gc_pkg::ApbDataW-1:0]  pwdata,
  output logic      [gc_pkg::ApbDataW-1:0]  prdata,
  output logic                              pready,
  gc_in_if.sink                             in_i,
  gc_out_if.source                          out_o
);
  import gc_pkg::*;

  logic [TickW-1:0] run_limit;
  gc_tmr_cmd_t      tmr_cmd;
  gc_tmr_sts_t      tmr_sts;
  logic             step;

  gc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .run_limit_o (run_limit)
  );

  gc_move_timer u_move_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (tmr_cmd),
    .run_limit_i (run_limit),
    .sts_o       (tmr_sts)
  );

  gc_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .tmr_sts_i (tmr_sts),
    .tmr_cmd_o (tmr_cmd),
    .step_o    (step)
  );
endmodule
`default_nettype wire
